FILE: sv/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 package
// Shared constants and the permutation memory request type.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned BoxDepth    = 256;
  localparam int unsigned AddrW       = 8;
  localparam int unsigned KeyWords    = 4;
  localparam int unsigned KeyMaxBytes = 32;
  localparam int unsigned KposW       = 5;
  localparam int unsigned KeyLenW     = 6;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;

  localparam logic [CfgIdxW-1:0] CfgKeyWord0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyWord1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyWord2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyWord3 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgKeyLength = 3'd4;

  localparam logic [KeyLenW-1:0] KeyLenReset = 6'd1;
  localparam logic [KeyLenW-1:0] KeyLenMin   = 6'd1;
  localparam logic [KeyLenW-1:0] KeyLenMax   = 6'd32;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re0;
    logic [AddrW-1:0] raddr0;
    logic             re1;
    logic [AddrW-1:0] raddr1;
  } ram_req_t;

endpackage

FILE: sv/rc4_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher core
// Key schedule and keystream generator sequenced over one permutation memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one byte per item in tdata; tuser is the start-of-message
//   flag. m_axis returns one byte per item: data XOR keystream.
//   cfg_* writes key words 0..3 (index 0..3) and the key length (index 4);
//   cfg_ready_o is always high. Write configuration only while idle.
//   A plain byte passes through StRdj, StWi and StWj before its result is
//   registered, and the block takes no new byte until it is idle again; the
//   chain of dependent reads of the permutation memory sets this (i, then j,
//   then the keystream entry). A byte with tuser set first refills the box
//   and runs the key schedule (StKra, StKw1 and StKw2 per round).
//   After reset the box is filled with the identity while s_axis_tready is
//   low; configuration writes are taken meanwhile.
//   A stalled receiver holds the result in the output register; one more
//   byte can be accepted and worked up to its final step behind it.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
  input  logic                         s_axis_tuser,   // [0] start_of_message
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // [7:0] out_byte
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rc4_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rc4_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam logic [2:0] StInit = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StRdj  = 3'd2;
  localparam logic [2:0] StWi   = 3'd3;
  localparam logic [2:0] StWj   = 3'd4;
  localparam logic [2:0] StKra  = 3'd5;
  localparam logic [2:0] StKw1  = 3'd6;
  localparam logic [2:0] StKw2  = 3'd7;

  localparam logic [rc4_pkg::AddrW-1:0] LastIdx = rc4_pkg::AddrW'(rc4_pkg::BoxDepth - 1);

  logic [2:0]                  state_q, state_d;
  logic [rc4_pkg::AddrW-1:0]   cnt_q, cnt_d;
  logic                        sched_q, sched_d;
  logic [rc4_pkg::AddrW-1:0]   i_q, i_d;
  logic [rc4_pkg::AddrW-1:0]   j_q, j_d;
  logic [rc4_pkg::AddrW-1:0]   acc_q, acc_d;
  logic [rc4_pkg::KposW-1:0]   kpos_q, kpos_d;
  logic [7:0]                  si_q, si_d;
  logic [7:0]                  sj_q, sj_d;
  logic [rc4_pkg::AddrW-1:0]   t_q, t_d;
  logic                        fwd_q, fwd_d;
  logic [7:0]                  fwd_val_q, fwd_val_d;
  logic [7:0]                  din_q, din_d;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  out_data_q, out_data_d;

  rc4_pkg::ram_req_t           ram_req;
  logic [7:0]                  rdata0;
  logic [7:0]                  rdata1;
  logic [7:0]                  key_byte;
  logic [rc4_pkg::KeyLenW-1:0] key_len;
  logic [7:0]                  s_rd;
  logic [7:0]                  ks;
  logic [rc4_pkg::KeyLenW-1:0] kpos_inc;
  logic                        in_acc;
  logic                        out_free;

  rc4_key_regs u_key_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .kpos_i      (kpos_q),
    .key_byte_o  (key_byte),
    .key_len_o   (key_len)
  );

  rc4_pbox_ram u_pbox_ram (
    .clk_i    (clk_i),
    .req_i    (ram_req),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_rd          = fwd_q ? fwd_val_q : rdata0;
  assign kpos_inc      = {1'b0, kpos_q} + rc4_pkg::KeyLenW'(1);

  always_comb begin
    priority if (t_q == j_q) begin
      ks = si_q;
    end else if (t_q == i_q) begin
      ks = sj_q;
    end else begin
      ks = rdata0;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sched_d     = sched_q;
    i_d         = i_q;
    j_d         = j_q;
    acc_d       = acc_q;
    kpos_d      = kpos_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    fwd_d       = fwd_q;
    fwd_val_d   = fwd_val_q;
    din_d       = din_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    ram_req     = '0;

    unique case (state_q)
      StInit: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_q;
        ram_req.wdata = cnt_q;
        cnt_d         = cnt_q + rc4_pkg::AddrW'(1);
        if (cnt_q == LastIdx) begin
          if (sched_q) begin
            ram_req.re0    = 1'b1;
            ram_req.raddr0 = '0;
            fwd_d          = 1'b0;
            acc_d          = '0;
            kpos_d         = '0;
            state_d        = StKra;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StIdle: begin
        if (in_acc) begin
          din_d = s_axis_tdata;
          if (s_axis_tuser) begin
            sched_d = 1'b1;
            cnt_d   = '0;
            state_d = StInit;
          end else begin
            i_d            = i_q + rc4_pkg::AddrW'(1);
            ram_req.re0    = 1'b1;
            ram_req.raddr0 = i_q + rc4_pkg::AddrW'(1);
            fwd_d          = 1'b0;
            state_d        = StRdj;
          end
        end
      end
      StRdj: begin
        si_d           = s_rd;
        j_d            = j_q + s_rd;
        ram_req.re1    = 1'b1;
        ram_req.raddr1 = j_q + s_rd;
        state_d        = StWi;
      end
      StWi: begin
        sj_d           = rdata1;
        ram_req.we     = 1'b1;
        ram_req.waddr  = i_q;
        ram_req.wdata  = rdata1;
        t_d            = si_q + rdata1;
        ram_req.re0    = 1'b1;
        ram_req.raddr0 = si_q + rdata1;
        state_d        = StWj;
      end
      StWj: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = j_q;
        ram_req.wdata = si_q;
        if (out_free) begin
          out_data_d  = din_q ^ ks;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      StKra: begin
        si_d           = s_rd;
        acc_d          = acc_q + s_rd + key_byte;
        ram_req.re1    = 1'b1;
        ram_req.raddr1 = acc_q + s_rd + key_byte;
        kpos_d         = (kpos_inc >= key_len) ? '0 : kpos_inc[rc4_pkg::KposW-1:0];
        state_d        = StKw1;
      end
      StKw1: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_q;
        ram_req.wdata = rdata1;
        state_d       = StKw2;
      end
      StKw2: begin
        ram_req.we     = 1'b1;
        ram_req.waddr  = acc_q;
        ram_req.wdata  = si_q;
        ram_req.re0    = 1'b1;
        fwd_val_d      = si_q;
        cnt_d          = cnt_q + rc4_pkg::AddrW'(1);
        if (cnt_q == LastIdx) begin
          ram_req.raddr0 = rc4_pkg::AddrW'(1);
          fwd_d          = (acc_q == rc4_pkg::AddrW'(1));
          sched_d        = 1'b0;
          i_d            = rc4_pkg::AddrW'(1);
          j_d            = '0;
          state_d        = StRdj;
        end else begin
          ram_req.raddr0 = cnt_q + rc4_pkg::AddrW'(1);
          fwd_d          = (acc_q == (cnt_q + rc4_pkg::AddrW'(1)));
          state_d        = StKra;
        end
      end
      default: state_d = StInit;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      cnt_q       <= '0;
      sched_q     <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      acc_q       <= '0;
      kpos_q      <= '0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sched_q     <= sched_d;
      i_q         <= i_d;
      j_q         <= j_d;
      acc_q       <= acc_d;
      kpos_q      <= kpos_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    sj_q       <= sj_d;
    t_q        <= t_d;
    fwd_val_q  <= fwd_val_d;
    din_q      <= din_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: sv/rc4_pbox_ram.sv
// ----------------------------------------------------------------------------
// RC4 permutation memory
// 256 x 8 memory, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rc4_pbox_ram (
  input  logic              clk_i,
  input  rc4_pkg::ram_req_t req_i,
  output logic [7:0]        rdata0_o,
  output logic [7:0]        rdata1_o
);

  logic [7:0] mem_q [rc4_pkg::BoxDepth];
  logic [7:0] rdata0_q;
  logic [7:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re0) begin
      rdata0_q <= mem_q[req_i.raddr0];
    end
    if (req_i.re1) begin
      rdata1_q <= mem_q[req_i.raddr1];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

FILE: sv/rc4_key_regs.sv
// ----------------------------------------------------------------------------
// RC4 key registers
// Key words and length, key byte select and clamped length.
// ----------------------------------------------------------------------------
module rc4_key_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [rc4_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rc4_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [rc4_pkg::KposW-1:0]     kpos_i,
  output logic [7:0]                    key_byte_o,
  output logic [rc4_pkg::KeyLenW-1:0]   key_len_o
);

  logic [rc4_pkg::CfgDataW-1:0] key_q [rc4_pkg::KeyWords];
  logic [rc4_pkg::KeyLenW-1:0]  len_q;
  logic [rc4_pkg::CfgDataW-1:0] word_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= '0;
      key_q[1] <= '0;
      key_q[2] <= '0;
      key_q[3] <= '0;
      len_q    <= rc4_pkg::KeyLenReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rc4_pkg::CfgKeyWord0:  key_q[0] <= cfg_data_i;
        rc4_pkg::CfgKeyWord1:  key_q[1] <= cfg_data_i;
        rc4_pkg::CfgKeyWord2:  key_q[2] <= cfg_data_i;
        rc4_pkg::CfgKeyWord3:  key_q[3] <= cfg_data_i;
        rc4_pkg::CfgKeyLength: len_q    <= cfg_data_i[rc4_pkg::KeyLenW-1:0];
        default: ;
      endcase
    end
  end

  assign word_sel   = key_q[kpos_i[4:3]];
  assign key_byte_o = word_sel[{kpos_i[2:0], 3'b000} +: 8];

  always_comb begin
    priority if (len_q < rc4_pkg::KeyLenMin) begin
      key_len_o = rc4_pkg::KeyLenMin;
    end else if (len_q > rc4_pkg::KeyLenMax) begin
      key_len_o = rc4_pkg::KeyLenMax;
    end else begin
      key_len_o = len_q;
    end
  end

endmodule

FILE: sv/rc4_sc_checker.sv
// ----------------------------------------------------------------------------
// RC4 port checker
// Port-level assertions, bound to the cipher core.
// ----------------------------------------------------------------------------
module rc4_sc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [7:0]                   s_axis_tdata,
  input logic                         s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [7:0]                   m_axis_tdata,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [rc4_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [rc4_pkg::CfgDataW-1:0] cfg_data_i
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input ready right after an accepted item");

  a_plain_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tuser |-> ##4 m_axis_tvalid)
    else $error("no result item four cycles after a plain byte");

  a_rise_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result item appeared while the core was idle");

endmodule

bind rc4_stream_cipher_core rc4_sc_checker u_rc4_sc_checker (.*);
